@@ rtl/core/gsr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gsr_pkg;

    // request codes
    localparam logic [2:0] REQ_WRITE   = 3'd0;
    localparam logic [2:0] REQ_READ    = 3'd1;
    localparam logic [2:0] REQ_ROT_CW  = 3'd2;
    localparam logic [2:0] REQ_ROT_CCW = 3'd3;
    localparam logic [2:0] REQ_COUNT   = 3'd4;

    // scan modes of the datapath
    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_COPY  = 3'd1;
    localparam logic [2:0] MODE_WBACK = 3'd2;
    localparam logic [2:0] MODE_HCNT  = 3'd3;
    localparam logic [2:0] MODE_VCNT  = 3'd4;

    // bound checks on 6 bit fields and their sums
    localparam int CMP_W = 7;

    localparam logic [5:0] GRID_SIZE_RST = 6'd32;

    typedef struct packed {
        logic       load;
        logic       wr;
        logic       cap_rd;
        logic       set_err;
        logic       start_scan;
        logic       step;
        logic [2:0] mode;
        logic       done;
    } t_cmd;

    typedef struct packed {
        logic is_write;
        logic is_read;
        logic is_rot;
        logic is_cnt;
        logic err;
        logic trivial;
        logic last;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/core/gsr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gsr_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/gsr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gsr_ctrl
    import gsr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_RDWAIT = 4'd2;
    localparam logic [3:0] S_COPY   = 4'd3;
    localparam logic [3:0] S_CDRAIN = 4'd4;
    localparam logic [3:0] S_WBACK  = 4'd5;
    localparam logic [3:0] S_CNTH   = 4'd6;
    localparam logic [3:0] S_HDRAIN = 4'd7;
    localparam logic [3:0] S_CNTV   = 4'd8;
    localparam logic [3:0] S_VDRAIN = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_stat.err) begin
                    o_cmd.set_err = 1'b1;
                    n_state       = S_DONE;
                end else if (i_stat.is_write) begin
                    o_cmd.wr = 1'b1;
                    n_state  = S_DONE;
                end else if (i_stat.is_read) begin
                    n_state = S_RDWAIT;
                end else if (i_stat.is_rot && !i_stat.trivial) begin
                    o_cmd.start_scan = 1'b1;
                    n_state          = S_COPY;
                end else if (i_stat.is_cnt) begin
                    o_cmd.start_scan = 1'b1;
                    n_state          = S_CNTH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RDWAIT: begin
                o_cmd.cap_rd = 1'b1;
                n_state      = S_DONE;
            end
            S_COPY: begin
                o_cmd.step = 1'b1;
                o_cmd.mode = MODE_COPY;
                if (i_stat.last) begin
                    n_state = S_CDRAIN;
                end
            end
            S_CDRAIN: begin
                o_cmd.start_scan = 1'b1;
                n_state          = S_WBACK;
            end
            S_WBACK: begin
                o_cmd.step = 1'b1;
                o_cmd.mode = MODE_WBACK;
                if (i_stat.last) begin
                    n_state = S_DONE;
                end
            end
            S_CNTH: begin
                o_cmd.step = 1'b1;
                o_cmd.mode = MODE_HCNT;
                if (i_stat.last) begin
                    n_state = S_HDRAIN;
                end
            end
            S_HDRAIN: begin
                o_cmd.start_scan = 1'b1;
                n_state          = S_CNTV;
            end
            S_CNTV: begin
                o_cmd.step = 1'b1;
                o_cmd.mode = MODE_VCNT;
                if (i_stat.last) begin
                    n_state = S_VDRAIN;
                end
            end
            S_VDRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.done = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/gsr_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gsr_dp
    import gsr_pkg::*;
#(
    parameter int GRID_MAX  = 32,
    parameter int CELL_BITS = 10
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [5:0] i_cfg_wdata,
    input  wire logic [2:0] i_req_type,
    input  wire logic [4:0] i_pos_x,
    input  wire logic [4:0] i_pos_y,
    input  wire logic [5:0] i_block_size,
    input  wire logic [9:0] i_cell_value,
    input  wire t_cmd       i_cmd,
    output t_stat           o_stat,
    output logic            o_result_valid,
    output logic [9:0]      o_read_value,
    output logic [10:0]     o_pair_count,
    output logic            o_op_error
);

    localparam int CW    = $clog2(GRID_MAX);
    localparam int DEPTH = GRID_MAX * GRID_MAX;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [AW-1:0] f_addr(input logic [CW-1:0] row,
                                             input logic [CW-1:0] col);
        return AW'(row) * AW'(GRID_MAX) + AW'(col);
    endfunction

    logic [5:0]           r_grid_size;
    logic [2:0]           r_type;
    logic [4:0]           r_x;
    logic [4:0]           r_y;
    logic [5:0]           r_n;
    logic [CELL_BITS-1:0] r_val;

    logic [5:0]    w_s;
    logic [CW-1:0] w_lim;
    logic [CW-1:0] w_xc;
    logic [CW-1:0] w_yc;
    logic          w_cell_err;
    logic          w_rot_err;

    logic [CW-1:0] r_o;
    logic [CW-1:0] r_i;
    logic          r_p_v;
    logic [2:0]    r_p_mode;
    logic [CW-1:0] r_p_o;
    logic [CW-1:0] r_p_i;

    logic [CELL_BITS-1:0] r_prev;
    logic [CELL_BITS-1:0] r_rdv;
    logic [10:0]          r_cnt;
    logic                 r_err;

    logic                 g_we;
    logic [AW-1:0]        g_waddr;
    logic [CELL_BITS-1:0] g_wdata;
    logic [AW-1:0]        g_raddr;
    logic [CELL_BITS-1:0] g_rdata;
    logic                 s_we;
    logic [AW-1:0]        s_waddr;
    logic [AW-1:0]        s_raddr;
    logic [CELL_BITS-1:0] s_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GRID_SIZE_RST;
        end else if (i_cfg_we) begin
            r_grid_size <= i_cfg_wdata;
        end
    end

    // clamp of the grid side in use
    always_comb begin
        if (r_grid_size < 6'd2) begin
            w_s = 6'd2;
        end else if (CMP_W'(r_grid_size) > CMP_W'(GRID_MAX)) begin
            w_s = 6'(GRID_MAX);
        end else begin
            w_s = r_grid_size;
        end
    end

    assign w_xc       = CW'(r_x);
    assign w_yc       = CW'(r_y);
    assign w_cell_err = (CMP_W'(r_x) >= CMP_W'(w_s)) || (CMP_W'(r_y) >= CMP_W'(w_s));
    assign w_rot_err  = (CMP_W'(r_x) + CMP_W'(r_n) > CMP_W'(w_s))
                     || (CMP_W'(r_y) + CMP_W'(r_n) > CMP_W'(w_s));
    assign w_lim      = (r_type == REQ_COUNT) ? CW'(w_s - 6'd1) : CW'(r_n - 6'd1);

    always_comb begin
        o_stat          = '0;
        o_stat.is_write = (r_type == REQ_WRITE);
        o_stat.is_read  = (r_type == REQ_READ);
        o_stat.is_rot   = (r_type == REQ_ROT_CW) || (r_type == REQ_ROT_CCW);
        o_stat.is_cnt   = (r_type == REQ_COUNT);
        o_stat.trivial  = (r_n < 6'd2);
        o_stat.last     = (r_o == w_lim) && (r_i == w_lim);
        o_stat.err      = ((o_stat.is_write || o_stat.is_read) && w_cell_err)
                       || (o_stat.is_rot && w_rot_err);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type <= i_req_type;
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
            r_n    <= i_block_size;
            r_val  <= CELL_BITS'(i_cell_value);
        end
    end

    // scan counters, inner index runs fastest
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_scan) begin
            r_o <= '0;
            r_i <= '0;
        end else if (i_cmd.step) begin
            if (r_i == w_lim) begin
                r_i <= '0;
                r_o <= r_o + CW'(1);
            end else begin
                r_i <= r_i + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else begin
            r_p_v <= i_cmd.step;
        end
        r_p_mode <= i_cmd.mode;
        r_p_o    <= r_o;
        r_p_i    <= r_i;
    end

    always_comb begin
        unique case (i_cmd.mode)
            MODE_COPY: g_raddr = f_addr(w_yc + r_o, w_xc + r_i);
            MODE_HCNT: g_raddr = f_addr(r_o, r_i);
            MODE_VCNT: g_raddr = f_addr(r_i, r_o);
            default:   g_raddr = f_addr(w_yc, w_xc);
        endcase
    end

    // source cell in the copied square for destination (r_o, r_i)
    assign s_raddr = (r_type == REQ_ROT_CW) ? f_addr(w_lim - r_i, r_o)
                                            : f_addr(r_i, w_lim - r_o);

    assign g_we    = i_cmd.wr || (r_p_v && (r_p_mode == MODE_WBACK));
    assign g_waddr = i_cmd.wr ? f_addr(w_yc, w_xc) : f_addr(w_yc + r_p_o, w_xc + r_p_i);
    assign g_wdata = i_cmd.wr ? r_val : s_rdata;
    assign s_we    = r_p_v && (r_p_mode == MODE_COPY);
    assign s_waddr = f_addr(r_p_o, r_p_i);

    gsr_ram #(.WIDTH(CELL_BITS), .DEPTH(DEPTH)) u_grid (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    gsr_ram #(.WIDTH(CELL_BITS), .DEPTH(DEPTH)) u_scratch (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (g_rdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (r_p_v) begin
            r_prev <= g_rdata;
        end
        if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (r_p_v && ((r_p_mode == MODE_HCNT) || (r_p_mode == MODE_VCNT))
                     && (r_p_i != '0) && (g_rdata == r_prev)) begin
            r_cnt <= r_cnt + 11'd1;
        end
        if (i_cmd.load) begin
            r_rdv <= '0;
        end else if (i_cmd.cap_rd) begin
            r_rdv <= g_rdata;
        end
        if (i_cmd.load) begin
            r_err <= 1'b0;
        end else if (i_cmd.set_err) begin
            r_err <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.done;
        end
        if (i_cmd.done) begin
            o_read_value <= 10'(r_rdv);
            o_pair_count <= r_cnt;
            o_op_error   <= r_err;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/grid_subsquare_rotator.sv @@
// Square grid of cells held in on-chip RAM, one request at a time. A request is
// taken when start is high and busy is low; its single result shows on the
// o_ outputs for exactly one cycle, marked by o_result_valid, and must be
// taken then: there is no back-pressure. A write, read, refused or unused
// request goes from decode to the result strobe, a read by way of a read wait
// state; a rotation of an n by n sub-square copies it into a scratch RAM, then
// writes it back in rotated order, one cell a cycle on the single read port;
// a pair count for grid side S runs a row scan then a column scan. Cells have
// no reset: load them before reading, rotating or counting. The user must write
// grid_size only while busy is low; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module grid_subsquare_rotator
    import gsr_pkg::*;
#(
    parameter int GRID_MAX  = 32,
    parameter int CELL_BITS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write, grid side in use
    input  wire logic        i_cfg_we,
    input  wire logic [5:0]  i_cfg_wdata,
    // request transfer
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [4:0]  i_pos_x,
    input  wire logic [4:0]  i_pos_y,
    input  wire logic [5:0]  i_block_size,
    input  wire logic [9:0]  i_cell_value,
    // result transfer, one cycle strobe
    output logic             o_result_valid,
    output logic [9:0]       o_read_value,
    output logic [10:0]      o_pair_count,
    output logic             o_op_error
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: decodes the request and steps the scans
    gsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // grid and scratch RAMs, scan counters, pair counter and result registers
    gsr_dp #(
        .GRID_MAX  (GRID_MAX),
        .CELL_BITS (CELL_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_req_type     (i_req_type),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_block_size   (i_block_size),
        .i_cell_value   (i_cell_value),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_result_valid (o_result_valid),
        .o_read_value   (o_read_value),
        .o_pair_count   (o_pair_count),
        .o_op_error     (o_op_error)
    );

endmodule

`default_nettype wire

@@ test/gsr_result_checker.sv @@
`timescale 1ns / 1ps

module gsr_result_checker
    import gsr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [5:0]  i_cfg_wdata,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [4:0]  i_pos_x,
    input  wire logic [4:0]  i_pos_y,
    input  wire logic [5:0]  i_block_size,
    input  wire logic [9:0]  i_cell_value,
    input  wire logic        i_result_valid,
    input  wire logic [9:0]  i_read_value,
    input  wire logic [10:0] i_pair_count,
    input  wire logic        i_op_error,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int SIDE = 32;

    typedef struct packed {
        logic [9:0]  read_value;
        logic [10:0] pair_count;
        logic        op_error;
    } t_answer;

    logic [9:0] cell_mirror [SIDE*SIDE];
    logic [9:0] rot_buf [SIDE*SIDE];
    logic [5:0] side_reg;
    t_answer    answers_due [$];

    function automatic int side_in_use();
        if (side_reg < 2) return 2;
        if (side_reg > SIDE) return SIDE;
        return side_reg;
    endfunction

    // applies one request to the mirror and returns its result
    function automatic t_answer serve_request(logic [2:0] kind, int x, int y, int n,
                                              logic [9:0] val);
        t_answer a;
        int s;
        int sr;
        int sc;
        a = '0;
        s = side_in_use();
        case (kind)
            REQ_WRITE: begin
                if (x >= s || y >= s) a.op_error = 1'b1;
                else cell_mirror[y*SIDE+x] = val;
            end
            REQ_READ: begin
                if (x >= s || y >= s) a.op_error = 1'b1;
                else a.read_value = cell_mirror[y*SIDE+x];
            end
            REQ_ROT_CW, REQ_ROT_CCW: begin
                if (x + n > s || y + n > s) begin
                    a.op_error = 1'b1;
                end else if (n >= 2) begin
                    for (int r = 0; r < n; r++)
                        for (int c = 0; c < n; c++)
                            rot_buf[r*SIDE+c] = cell_mirror[(y+r)*SIDE+x+c];
                    for (int r = 0; r < n; r++)
                        for (int c = 0; c < n; c++) begin
                            sr = (kind == REQ_ROT_CW) ? n - 1 - c : c;
                            sc = (kind == REQ_ROT_CW) ? r : n - 1 - r;
                            cell_mirror[(y+r)*SIDE+x+c] = rot_buf[sr*SIDE+sc];
                        end
                end
            end
            REQ_COUNT: begin
                for (int r = 0; r < s; r++)
                    for (int c = 0; c + 1 < s; c++)
                        if (cell_mirror[r*SIDE+c] == cell_mirror[r*SIDE+c+1])
                            a.pair_count++;
                for (int r = 0; r + 1 < s; r++)
                    for (int c = 0; c < s; c++)
                        if (cell_mirror[r*SIDE+c] == cell_mirror[(r+1)*SIDE+c])
                            a.pair_count++;
            end
            default: ;
        endcase
        return a;
    endfunction

    assign o_pending = answers_due.size();

    initial begin
        o_fail_count = 0;
        side_reg = GRID_SIZE_RST;
        foreach (cell_mirror[i]) cell_mirror[i] = '0;
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            side_reg = GRID_SIZE_RST;
        end else begin
            // compare first, then queue the transfer taken at this edge
            if (i_result_valid) begin
                if (answers_due.size() == 0) begin
                    $error("result strobe with nothing expected");
                    o_fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    if (i_read_value !== want.read_value) begin
                        $error("read_value expected %0d got %0d", want.read_value,
                               i_read_value);
                        o_fail_count++;
                    end
                    if (i_pair_count !== want.pair_count) begin
                        $error("pair_count expected %0d got %0d", want.pair_count,
                               i_pair_count);
                        o_fail_count++;
                    end
                    if (i_op_error !== want.op_error) begin
                        $error("op_error expected %0d got %0d", want.op_error, i_op_error);
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy)
                answers_due.push_back(serve_request(i_req_type, i_pos_x, i_pos_y,
                                                    i_block_size, i_cell_value));
            if (i_cfg_we) side_reg = i_cfg_wdata;
        end
    end

endmodule

@@ test/tb_grid_subsquare_rotator.sv @@
`timescale 1ns / 1ps

module tb_grid_subsquare_rotator;
    import gsr_pkg::*;

    // first of the request codes the block ignores
    localparam logic [2:0] REQ_IDLE_LO = 3'd5;
    localparam logic [2:0] REQ_IDLE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 20_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [5:0]  i_cfg_wdata = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_req_type = '0;
    logic [4:0]  i_pos_x = '0;
    logic [4:0]  i_pos_y = '0;
    logic [5:0]  i_block_size = '0;
    logic [9:0]  i_cell_value = '0;
    logic        o_result_valid;
    logic [9:0]  o_read_value;
    logic [10:0] o_pair_count;
    logic        o_op_error;

    int fail_count;
    int answers_open;
    int cycle_count = 0;
    int gap_pct = 0;
    int side_now = 32;

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    grid_subsquare_rotator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_block_size(i_block_size), .i_cell_value(i_cell_value),
        .o_result_valid(o_result_valid), .o_read_value(o_read_value),
        .o_pair_count(o_pair_count), .o_op_error(o_op_error)
    );

    gsr_result_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_start(start), .i_busy(busy),
        .i_req_type(i_req_type), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_block_size(i_block_size), .i_cell_value(i_cell_value),
        .i_result_valid(o_result_valid), .i_read_value(o_read_value),
        .i_pair_count(o_pair_count), .i_op_error(o_op_error),
        .o_fail_count(fail_count), .o_pending(answers_open)
    );

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // one request transfer, with random idle cycles ahead of it
    task automatic issue(logic [2:0] kind, logic [4:0] x, logic [4:0] y,
                         logic [5:0] n, logic [9:0] val);
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_req_type = kind;
        i_pos_x = x;
        i_pos_y = y;
        i_block_size = n;
        i_cell_value = val;
        // accepted at the first edge where busy is low
        do @(posedge i_clk); while (busy);
    endtask

    // hold off until every result is back, plus the short-op latency
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (answers_open != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_side(logic [5:0] v);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        side_now = (v < 2) ? 2 : (v > 32) ? 32 : v;
    endtask

    // coordinate mostly inside the grid in use, sometimes anywhere
    function automatic logic [4:0] pick_pos();
        if ($urandom_range(9) == 0) return 5'($urandom);
        return 5'($urandom_range(side_now - 1));
    endfunction

    // few distinct values so pair counts are interesting
    function automatic logic [9:0] pick_val();
        if ($urandom_range(1)) return 10'($urandom_range(3));
        return 10'($urandom);
    endfunction

    task automatic random_item();
        int pick;
        int n;
        logic [4:0] x;
        logic [4:0] y;
        pick = $urandom_range(99);
        if (pick < 30) begin
            issue(REQ_WRITE, pick_pos(), pick_pos(), 6'($urandom), pick_val());
        end else if (pick < 55) begin
            issue(REQ_READ, pick_pos(), pick_pos(), 6'($urandom), 10'($urandom));
        end else if (pick < 88) begin
            // well-formed rotations dominate, small sizes mostly
            if ($urandom_range(9) == 0) n = $urandom_range(63);
            else if ($urandom_range(9) == 0) n = $urandom_range(side_now);
            else n = $urandom_range((side_now < 5) ? side_now : 5);
            if (n <= side_now && $urandom_range(7) != 0) begin
                x = 5'($urandom_range(side_now - n));
                y = 5'($urandom_range(side_now - n));
            end else begin
                x = pick_pos();
                y = pick_pos();
            end
            issue($urandom_range(1) ? REQ_ROT_CW : REQ_ROT_CCW, x, y, 6'(n),
                  10'($urandom));
        end else if (pick < 95) begin
            issue(REQ_COUNT, 5'($urandom), 5'($urandom), 6'($urandom), 10'($urandom));
        end else begin
            issue(3'($urandom_range(REQ_IDLE_HI, REQ_IDLE_LO)), 5'($urandom),
                  5'($urandom), 6'($urandom), 10'($urandom));
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // load every cell at full size so nothing unwritten is ever touched
        for (int r = 0; r < 32; r++)
            for (int c = 0; c < 32; c++)
                issue(REQ_WRITE, 5'(c), 5'(r), 6'($urandom), pick_val());

        // directed part
        issue(REQ_WRITE, 5'd31, 5'd31, 6'd0, 10'd1023);
        issue(REQ_READ, 5'd31, 5'd31, 6'd63, 10'd0);
        issue(REQ_READ, 5'd0, 5'd0, 6'd0, 10'd1023);
        issue(REQ_ROT_CW, 5'd0, 5'd0, 6'd32, 10'd0);     // whole grid
        issue(REQ_ROT_CCW, 5'd0, 5'd0, 6'd63, 10'd0);    // far past the edge
        issue(REQ_COUNT, 5'd31, 5'd31, 6'd63, 10'd1023);
        set_side(6'd8);
        issue(REQ_WRITE, 5'd31, 5'd0, 6'd0, 10'd5);      // off the grid
        issue(REQ_READ, 5'd0, 5'd9, 6'd0, 10'd0);        // off the grid
        issue(REQ_WRITE, 5'd7, 5'd7, 6'd0, 10'd0);
        issue(REQ_ROT_CW, 5'd0, 5'd0, 6'd8, 10'd0);
        issue(REQ_ROT_CCW, 5'd5, 5'd5, 6'd3, 10'd0);     // touches the corner
        issue(REQ_ROT_CW, 5'd6, 5'd0, 6'd3, 10'd0);      // one column too far
        issue(REQ_ROT_CCW, 5'd0, 5'd6, 6'd3, 10'd0);     // one row too far
        issue(REQ_ROT_CW, 5'd7, 5'd7, 6'd0, 10'd0);      // trivial, size zero
        issue(REQ_ROT_CCW, 5'd7, 5'd7, 6'd1, 10'd0);     // trivial, size one
        issue(REQ_ROT_CW, 5'd8, 5'd0, 6'd0, 10'd0);      // trivial but off the grid
        issue(REQ_COUNT, 5'd0, 5'd0, 6'd0, 10'd0);
        for (int k = REQ_IDLE_LO; k <= REQ_IDLE_HI; k++)
            issue(3'(k), 5'd31, 5'd31, 6'd63, 10'd1023);
        set_side(6'd0);                                  // clamps to two
        issue(REQ_COUNT, 5'd0, 5'd0, 6'd0, 10'd0);
        issue(REQ_ROT_CW, 5'd0, 5'd0, 6'd2, 10'd0);
        set_side(6'd63);                                 // clamps to full size
        issue(REQ_COUNT, 5'd0, 5'd0, 6'd0, 10'd0);

        // random part in three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            gap_pct = (phase == 0) ? 34 : (phase == 1) ? 80 : 0;
            for (int i = 0; i < 168; i++) begin
                if (i % 42 == 0) begin
                    case ($urandom_range(5))
                        0: set_side(6'd2);
                        1: set_side(6'd32);
                        2: set_side(6'd1);
                        3: set_side(6'd33);
                        default: set_side(6'($urandom_range(12, 3)));
                    endcase
                end
                if (i == 100) drain();               // sender waits for all results
                random_item();
            end
        end

        @(negedge i_clk);
        start = 1'b0;
        while (answers_open != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ grid_subsquare_rotator.f @@
rtl/core/gsr_pkg.sv
rtl/core/gsr_ram.sv
rtl/core/gsr_ctrl.sv
rtl/core/gsr_dp.sv
rtl/core/grid_subsquare_rotator.sv
test/gsr_result_checker.sv
test/tb_grid_subsquare_rotator.sv
